// ===== hdl/tlca_pkg.sv =====
package tlca_pkg;

  localparam int unsigned NODE_W          = 11;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned MAX_NODES_DEF   = 1024;
  localparam int unsigned LIFT_LEVELS_DEF = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE   = 2'd0,
    KIND_BUILD  = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLR,
    ST_SEED,
    ST_POP,
    ST_POP_W,
    ST_DEP_W,
    ST_E_RD,
    ST_E_CHK,
    ST_D_CHK,
    ST_F_RD1,
    ST_F_RD2,
    ST_F_WR,
    ST_Q_DA,
    ST_Q_DB,
    ST_Q_CMP,
    ST_LIFT,
    ST_LIFT_W,
    ST_MEET,
    ST_M_RD,
    ST_M_CHK
  } state_e;

endpackage

// ===== hdl/tlca_ram.sv =====
module tlca_ram #(
  parameter int unsigned DEPTH     = 2,
  parameter int unsigned WIDTH     = 1,
  parameter bit          DUAL_READ = 1'b0,
  parameter int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr0_i,
  output logic [WIDTH-1:0] rdata0_o,
  input  logic [AW-1:0]    raddr1_i,
  output logic [WIDTH-1:0] rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem[raddr0_i];
  end

  assign rdata0_o = rdata0_q;

  generate
    if (DUAL_READ) begin : g_port1
      logic [WIDTH-1:0] rdata1_q;
      always_ff @(posedge clk_i) begin
        rdata1_q <= mem[raddr1_i];
      end
      assign rdata1_o = rdata1_q;
    end else begin : g_no_port1
      assign rdata1_o = '0;
    end
  endgenerate

endmodule

// ===== hdl/tree_lca_binary_lifting_core.sv =====
// Lowest common ancestor engine over a tree built from loaded edges. After reset the
// block stays busy while it clears the depth table. An edge item is stored, if the
// edge table has room, while the block stays idle. A build item clears the depth
// table and the first ancestor level, then walks breadth first from node 1, scanning
// every stored edge for each reached node, and finally fills the ancestor table over
// (LIFT_LEVELS-1)*(n+1) entries, n being the effective node count. A query reads both
// depths, lifts the deeper node and then steps both nodes up until they meet; a query
// that names node 0 or an unreached node answers at the depth compare, without lifting.
// The table memories have registered reads, so each dependent lookup waits on the
// previous read. The result appears on ancestor_node_o for exactly one cycle with
// done_o high; the receiver cannot stall it, so it must capture the item in that cycle.
module tree_lca_binary_lifting_core #(
  parameter int unsigned MAX_NODES   = tlca_pkg::MAX_NODES_DEF,
  parameter int unsigned LIFT_LEVELS = tlca_pkg::LIFT_LEVELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [tlca_pkg::KIND_W-1:0] kind_i,
  input  logic [tlca_pkg::NODE_W-1:0] node_a_i,
  input  logic [tlca_pkg::NODE_W-1:0] node_b_i,
  output logic                        done_o,
  output logic [tlca_pkg::NODE_W-1:0] ancestor_node_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tlca_pkg::NODE_W-1:0] cfg_data_i
);

  import tlca_pkg::*;

  localparam int unsigned NW     = $clog2(MAX_NODES + 1);
  localparam int unsigned CW     = (NW > NODE_W) ? NW : NODE_W;
  localparam int unsigned LW     = $clog2(LIFT_LEVELS);
  localparam int unsigned ROW    = MAX_NODES + 1;
  localparam int unsigned ADEPTH = LIFT_LEVELS * ROW;
  localparam int unsigned AAW    = $clog2(ADEPTH);
  localparam int unsigned EDEPTH = MAX_NODES - 1;
  localparam int unsigned EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
  localparam int unsigned ETW    = $clog2(MAX_NODES);
  localparam int unsigned QAW    = $clog2(MAX_NODES);
  localparam int unsigned EW     = 2 * NODE_W;

  function automatic logic [AAW-1:0] anc_addr(input logic [LW-1:0] lv,
                                              input logic [NW-1:0] nd);
    anc_addr = AAW'(lv) * AAW'(ROW) + AAW'(nd);
  endfunction

  function automatic logic [NW-1:0] clamp_node(input logic [NODE_W-1:0] x,
                                               input logic [NW-1:0] nl);
    clamp_node = (CW'(x) > CW'(nl)) ? '0 : NW'(x);
  endfunction

  state_e            state_q, state_d;
  logic [NODE_W-1:0] node_count_q, node_count_d;
  logic [ETW-1:0]    edge_total_q, edge_total_d;
  logic              done_q, done_d;
  logic [NW-1:0]     idx_q, idx_d;
  logic [NW-1:0]     head_q, head_d;
  logic [NW-1:0]     tail_q, tail_d;
  logic [NW-1:0]     cur_q, cur_d;
  logic [NW-1:0]     curdep_q, curdep_d;
  logic [NW-1:0]     nb_q, nb_d;
  logic [ETW-1:0]    e_q, e_d;
  logic [LW-1:0]     lv_q, lv_d;
  logic [NW-1:0]     a_q, a_d;
  logic [NW-1:0]     b_q, b_d;
  logic [NW-1:0]     da_q, da_d;
  logic [NW-1:0]     diff_q, diff_d;
  logic [NW-1:0]     res_q, res_d;

  logic [NW-1:0]     n_live;

  logic              dep_we;
  logic [NW-1:0]     dep_waddr, dep_wdata, dep_raddr, dep_rdata, dep_unused;
  logic              anc_we;
  logic [AAW-1:0]    anc_waddr, anc_ra0, anc_ra1;
  logic [NW-1:0]     anc_wdata, anc_rd0, anc_rd1;
  logic              edge_we;
  logic [EAW-1:0]    edge_waddr, edge_raddr;
  logic [EW-1:0]     edge_wdata, edge_rdata, edge_unused;
  logic              q_we;
  logic [QAW-1:0]    q_waddr, q_raddr;
  logic [NW-1:0]     q_wdata, q_rdata, q_unused;

  logic [NODE_W-1:0] ex, ey;
  logic              e_ok, hit_x, nb_hit, e_more;
  logic [NW-1:0]     nb_sel;
  logic              top_hit;
  logic [LW-1:0]     low_lv, lift_lv;
  logic [NW-1:0]     diff_next;

  // Effective node count: zero counts as one, values above capacity saturate.
  always_comb begin
    if (node_count_q == '0) begin
      n_live = NW'(1);
    end else if (CW'(node_count_q) > CW'(MAX_NODES)) begin
      n_live = NW'(MAX_NODES);
    end else begin
      n_live = NW'(node_count_q);
    end
  end

  // Edges with an endpoint outside 1..n are skipped by the walk.
  assign ex     = edge_rdata[EW-1:NODE_W];
  assign ey     = edge_rdata[NODE_W-1:0];
  assign e_ok   = (ex != '0) && (ey != '0) &&
                  (CW'(ex) <= CW'(n_live)) && (CW'(ey) <= CW'(n_live));
  assign hit_x  = (CW'(ex) == CW'(cur_q));
  assign nb_sel = hit_x ? NW'(ey) : NW'(ex);
  assign nb_hit = e_ok && (hit_x || (CW'(ey) == CW'(cur_q)));
  assign e_more = (ETW'(e_q + ETW'(1)) != edge_total_q);

  // Lifting order does not matter since jumps compose; take full top-level
  // jumps while the difference is large, then the remaining set bits.
  always_comb begin
    logic [NW-1:0] dbit;
    low_lv = '0;
    for (int k = LIFT_LEVELS - 2; k >= 0; k--) begin
      dbit = diff_q >> k;
      if (dbit[0]) begin
        low_lv = LW'(k);
      end
    end
  end

  assign top_hit   = ((diff_q >> (LIFT_LEVELS - 1)) != '0);
  assign lift_lv   = top_hit ? LW'(LIFT_LEVELS - 1) : low_lv;
  assign diff_next = top_hit ? NW'(diff_q - (NW'(1) << (LIFT_LEVELS - 1)))
                             : (diff_q & ~(NW'(1) << low_lv));

  always_comb begin
    state_d      = state_q;
    node_count_d = node_count_q;
    edge_total_d = edge_total_q;
    done_d       = 1'b0;
    idx_d        = idx_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cur_d        = cur_q;
    curdep_d     = curdep_q;
    nb_d         = nb_q;
    e_d          = e_q;
    lv_d         = lv_q;
    a_d          = a_q;
    b_d          = b_q;
    da_d         = da_q;
    diff_d       = diff_q;
    res_d        = res_q;

    dep_we     = 1'b0;
    dep_waddr  = idx_q;
    dep_wdata  = '0;
    dep_raddr  = a_q;
    anc_we     = 1'b0;
    anc_waddr  = anc_addr('0, idx_q);
    anc_wdata  = '0;
    anc_ra0    = anc_addr(lv_q, a_q);
    anc_ra1    = anc_addr(lv_q, b_q);
    edge_we    = 1'b0;
    edge_waddr = edge_total_q[EAW-1:0];
    edge_wdata = {node_a_i, node_b_i};
    edge_raddr = e_q[EAW-1:0];
    q_we       = 1'b0;
    q_waddr    = tail_q[QAW-1:0];
    q_wdata    = nb_q;
    q_raddr    = head_q[QAW-1:0];

    if (cfg_valid_i) begin
      node_count_d = cfg_data_i;
    end

    case (state_q)
      ST_INIT: begin
        // Every node reads as unreached until the first build.
        dep_we = 1'b1;
        if (idx_q == NW'(MAX_NODES)) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = NW'(idx_q + NW'(1));
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          case (kind_i)
            KIND_EDGE: begin
              if (edge_total_q != ETW'(MAX_NODES - 1)) begin
                edge_we      = 1'b1;
                edge_total_d = ETW'(edge_total_q + ETW'(1));
              end
            end
            KIND_BUILD: begin
              idx_d   = '0;
              state_d = ST_CLR;
            end
            KIND_QUERY: begin
              a_d     = clamp_node(node_a_i, n_live);
              b_d     = clamp_node(node_b_i, n_live);
              state_d = ST_Q_DA;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        dep_we    = 1'b1;
        anc_we    = 1'b1;
        if (idx_q == NW'(MAX_NODES)) begin
          state_d = ST_SEED;
        end else begin
          idx_d = NW'(idx_q + NW'(1));
        end
      end
      ST_SEED: begin
        dep_we    = 1'b1;
        dep_waddr = NW'(1);
        dep_wdata = NW'(1);
        q_we      = 1'b1;
        q_waddr   = '0;
        q_wdata   = NW'(1);
        head_d    = '0;
        tail_d    = NW'(1);
        state_d   = ST_POP;
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          lv_d    = LW'(1);
          idx_d   = '0;
          state_d = ST_F_RD1;
        end else begin
          head_d  = NW'(head_q + NW'(1));
          state_d = ST_POP_W;
        end
      end
      ST_POP_W: begin
        cur_d     = q_rdata;
        dep_raddr = q_rdata;
        state_d   = ST_DEP_W;
      end
      ST_DEP_W: begin
        curdep_d = dep_rdata;
        e_d      = '0;
        state_d  = (edge_total_q == '0) ? ST_POP : ST_E_RD;
      end
      ST_E_RD: begin
        state_d = ST_E_CHK;
      end
      ST_E_CHK: begin
        if (nb_hit) begin
          nb_d      = nb_sel;
          dep_raddr = nb_sel;
          state_d   = ST_D_CHK;
        end else if (e_more) begin
          e_d     = ETW'(e_q + ETW'(1));
          state_d = ST_E_RD;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_D_CHK: begin
        // A depth code of zero marks a node not yet reached.
        if (dep_rdata == '0) begin
          dep_we    = 1'b1;
          dep_waddr = nb_q;
          dep_wdata = NW'(curdep_q + NW'(1));
          anc_we    = 1'b1;
          anc_waddr = anc_addr('0, nb_q);
          anc_wdata = cur_q;
          q_we      = 1'b1;
          tail_d    = NW'(tail_q + NW'(1));
        end
        if (e_more) begin
          e_d     = ETW'(e_q + ETW'(1));
          state_d = ST_E_RD;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_F_RD1: begin
        anc_ra0 = anc_addr(LW'(lv_q - LW'(1)), idx_q);
        state_d = ST_F_RD2;
      end
      ST_F_RD2: begin
        anc_ra0 = anc_addr(LW'(lv_q - LW'(1)), anc_rd0);
        state_d = ST_F_WR;
      end
      ST_F_WR: begin
        anc_we    = 1'b1;
        anc_waddr = anc_addr(lv_q, idx_q);
        anc_wdata = anc_rd0;
        if (idx_q == n_live) begin
          idx_d = '0;
          if (lv_q == LW'(LIFT_LEVELS - 1)) begin
            state_d = ST_IDLE;
          end else begin
            lv_d    = LW'(lv_q + LW'(1));
            state_d = ST_F_RD1;
          end
        end else begin
          idx_d   = NW'(idx_q + NW'(1));
          state_d = ST_F_RD1;
        end
      end
      ST_Q_DA: begin
        dep_raddr = a_q;
        state_d   = ST_Q_DB;
      end
      ST_Q_DB: begin
        da_d      = dep_rdata;
        dep_raddr = b_q;
        state_d   = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        // Node 0 and unreached nodes have only node 0 above them, so two
        // different nodes meet there.
        if ((da_q == '0) || (dep_rdata == '0)) begin
          res_d   = (a_q == b_q) ? a_q : '0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (da_q < dep_rdata) begin
            a_d    = b_q;
            b_d    = a_q;
            diff_d = NW'(dep_rdata - da_q);
          end else begin
            diff_d = NW'(da_q - dep_rdata);
          end
          state_d = ST_LIFT;
        end
      end
      ST_LIFT: begin
        if (diff_q == '0) begin
          state_d = ST_MEET;
        end else begin
          anc_ra0 = anc_addr(lift_lv, a_q);
          diff_d  = diff_next;
          state_d = ST_LIFT_W;
        end
      end
      ST_LIFT_W: begin
        a_d     = anc_rd0;
        state_d = ST_LIFT;
      end
      ST_MEET: begin
        if (a_q == b_q) begin
          res_d   = a_q;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          lv_d    = LW'(LIFT_LEVELS - 1);
          state_d = ST_M_RD;
        end
      end
      ST_M_RD: begin
        state_d = ST_M_CHK;
      end
      ST_M_CHK: begin
        // The top level and level 0 repeat until their ancestors agree; the levels between descend once.
        if (anc_rd0 != anc_rd1) begin
          a_d = anc_rd0;
          b_d = anc_rd1;
          if ((lv_q != '0) && (lv_q != LW'(LIFT_LEVELS - 1))) begin
            lv_d = LW'(lv_q - LW'(1));
          end
          state_d = ST_M_RD;
        end else if (lv_q == '0) begin
          res_d   = anc_rd0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          lv_d    = LW'(lv_q - LW'(1));
          state_d = ST_M_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      node_count_q <= NODE_W'(1);
      edge_total_q <= '0;
      done_q       <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      edge_total_q <= edge_total_d;
      done_q       <= done_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q   <= head_d;
    tail_q   <= tail_d;
    cur_q    <= cur_d;
    curdep_q <= curdep_d;
    nb_q     <= nb_d;
    e_q      <= e_d;
    lv_q     <= lv_d;
    a_q      <= a_d;
    b_q      <= b_d;
    da_q     <= da_d;
    diff_q   <= diff_d;
    res_q    <= res_d;
  end

  tlca_ram #(
    .DEPTH     (MAX_NODES + 1),
    .WIDTH     (NW),
    .DUAL_READ (1'b0)
  ) u_depth (
    .clk_i    (clk_i),
    .we_i     (dep_we),
    .waddr_i  (dep_waddr),
    .wdata_i  (dep_wdata),
    .raddr0_i (dep_raddr),
    .rdata0_o (dep_rdata),
    .raddr1_i (dep_raddr),
    .rdata1_o (dep_unused)
  );

  tlca_ram #(
    .DEPTH     (ADEPTH),
    .WIDTH     (NW),
    .DUAL_READ (1'b1)
  ) u_anc (
    .clk_i    (clk_i),
    .we_i     (anc_we),
    .waddr_i  (anc_waddr),
    .wdata_i  (anc_wdata),
    .raddr0_i (anc_ra0),
    .rdata0_o (anc_rd0),
    .raddr1_i (anc_ra1),
    .rdata1_o (anc_rd1)
  );

  tlca_ram #(
    .DEPTH     (EDEPTH),
    .WIDTH     (EW),
    .DUAL_READ (1'b0)
  ) u_edge (
    .clk_i    (clk_i),
    .we_i     (edge_we),
    .waddr_i  (edge_waddr),
    .wdata_i  (edge_wdata),
    .raddr0_i (edge_raddr),
    .rdata0_o (edge_rdata),
    .raddr1_i (edge_raddr),
    .rdata1_o (edge_unused)
  );

  tlca_ram #(
    .DEPTH     (MAX_NODES),
    .WIDTH     (NW),
    .DUAL_READ (1'b0)
  ) u_queue (
    .clk_i    (clk_i),
    .we_i     (q_we),
    .waddr_i  (q_waddr),
    .wdata_i  (q_wdata),
    .raddr0_i (q_raddr),
    .rdata0_o (q_rdata),
    .raddr1_i (q_raddr),
    .rdata1_o (q_unused)
  );

  assign busy_o          = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign ancestor_node_o = NODE_W'(res_q);
  assign cfg_ready_o     = 1'b1;

endmodule

// ===== hdl/tlca_checker.sv =====
module tlca_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [tlca_pkg::KIND_W-1:0] kind_i,
  input logic                        done_o
);

  import tlca_pkg::*;

  // A result closes a busy period and is shown once.
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && $past(busy_o)))
    else $error("result shown without a preceding busy period");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (kind_i == KIND_QUERY)) |=> busy_o)
    else $error("query item accepted but block not busy");

  a_edge_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (kind_i == KIND_EDGE)) |=> (!busy_o && !done_o))
    else $error("edge item caused work or a result");

endmodule

bind tree_lca_binary_lifting_core tlca_checker u_tlca_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .kind_i  (kind_i),
  .done_o  (done_o)
);

// ===== sim/lca_checker.sv =====
`timescale 1ns / 100ps

// Watches the item, result and register channels of the LCA core, keeps its own
// copy of the tree tables and checks every ancestor result in order.
module lca_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [tlca_pkg::KIND_W-1:0] kind_i,
  input  logic [tlca_pkg::NODE_W-1:0] node_a_i,
  input  logic [tlca_pkg::NODE_W-1:0] node_b_i,
  input  logic                        done_i,
  input  logic [tlca_pkg::NODE_W-1:0] ancestor_node_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [tlca_pkg::NODE_W-1:0] cfg_data_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  import tlca_pkg::*;

  localparam int NODES  = MAX_NODES_DEF;
  localparam int LEVELS = LIFT_LEVELS_DEF;

  logic [NODE_W-1:0] node_count_q;
  logic [NODE_W-1:0] edge_a [NODES-1];
  logic [NODE_W-1:0] edge_b [NODES-1];
  int                edge_total;
  int                depth [NODES+1];
  logic [NODE_W-1:0] lift [LEVELS][NODES+1];
  int                walk_q [NODES+1];

  logic [NODE_W-1:0] expected_ancestors [$];

  function automatic int live_nodes();
    int n;
    n = node_count_q;
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    return n;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i <= NODES; i++) begin
      depth[i] = -1;
      for (int r = 0; r < LEVELS; r++) lift[r][i] = '0;
    end
  endfunction

  function automatic void walk_tree();
    int n, head, tail, cur, x, y, nb;
    n = live_nodes();
    head = 0;
    tail = 0;
    clear_tables();
    depth[1] = 0;
    walk_q[tail++] = 1;
    while (head < tail) begin
      cur = walk_q[head++];
      for (int e = 0; e < edge_total; e++) begin
        x = edge_a[e];
        y = edge_b[e];
        if (x == 0 || y == 0 || x > n || y > n) continue;
        if (x == cur) nb = y;
        else if (y == cur) nb = x;
        else continue;
        if (depth[nb] == -1 && tail <= NODES) begin
          walk_q[tail++] = nb;
          depth[nb] = depth[cur] + 1;
          lift[0][nb] = NODE_W'(cur);
        end
      end
    end
    for (int r = 1; r < LEVELS; r++)
      for (int i = 1; i <= n; i++) lift[r][i] = lift[r-1][lift[r-1][i]];
  endfunction

  function automatic logic [NODE_W-1:0] lowest_ancestor(logic [NODE_W-1:0] a_in,
                                                        logic [NODE_W-1:0] b_in);
    int n, r, reps, guard;
    int unsigned diff;
    logic [NODE_W-1:0] a, b, t;
    n = live_nodes();
    a = a_in;
    b = b_in;
    if (a > n) a = '0;
    if (b > n) b = '0;
    if (depth[a] < depth[b]) begin
      t = a;
      a = b;
      b = t;
    end
    diff = depth[a] - depth[b];
    // Bits above the top level are covered by repeated top-level jumps.
    for (r = 0; diff != 0 && r < 32; r++) begin
      if (diff & 1) begin
        if (r < LEVELS) begin
          a = lift[r][a];
        end else begin
          reps = 1 << (r - LEVELS + 1);
          for (int k = 0; k < reps; k++) a = lift[LEVELS-1][a];
        end
      end
      diff = diff >> 1;
    end
    for (guard = 0; a != b && guard < NODES + 2; guard++) begin
      r = 0;
      while (r < LEVELS && lift[r][a] != lift[r][b]) r++;
      if (r > 0) r--;
      a = lift[r][a];
      b = lift[r][b];
    end
    return a;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q = 1;
      edge_total = 0;
      clear_tables();
      expected_ancestors.delete();
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (expected_ancestors.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", ancestor_node_i));
        end else begin
          logic [NODE_W-1:0] want;
          want = expected_ancestors.pop_front();
          if (ancestor_node_i !== want)
            report_mismatch($sformatf("ancestor %0d, predicted %0d", ancestor_node_i, want));
        end
      end
      if (cfg_valid_i && cfg_ready_i) node_count_q = cfg_data_i;
      if (start_i && !busy_i) begin
        case (kind_i)
          KIND_EDGE: begin
            if (edge_total < NODES - 1) begin
              edge_a[edge_total] = node_a_i;
              edge_b[edge_total] = node_b_i;
              edge_total++;
            end
          end
          KIND_BUILD: walk_tree();
          KIND_QUERY: begin
            expected_ancestors = {expected_ancestors,
                                  lowest_ancestor(node_a_i, node_b_i)};
          end
          default: ;
        endcase
      end
      pending_o = expected_ancestors.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tlca_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic [NODE_W-1:0] node_a_i = '0;
  logic [NODE_W-1:0] node_b_i = '0;
  logic              done_o;
  logic [NODE_W-1:0] ancestor_node_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [NODE_W-1:0] cfg_data_i = '0;
  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                live = 1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  tree_lca_binary_lifting_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .kind_i         (kind_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .done_o         (done_o),
    .ancestor_node_o(ancestor_node_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  lca_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .kind_i         (kind_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .done_i         (done_o),
    .ancestor_node_i(ancestor_node_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short gap, now and then a long pause.
  task automatic idle_gap();
    int r, len;
    r = $urandom_range(0, 99);
    if (r < 60) len = 0;
    else if (r < 92) len = $urandom_range(1, 3);
    else len = $urandom_range(10, 60);
    if (len > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end
  endtask

  // Start stays high when the next item follows directly.
  task automatic send_item(kind_e k, int a, int b);
    @(negedge clk_i);
    start_i  = 1'b1;
    kind_i   = k;
    node_a_i = NODE_W'(a);
    node_b_i = NODE_W'(b);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    idle_gap();
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_node_count(int v);
    settle();
    cfg_valid_i = 1'b1;
    cfg_data_i  = NODE_W'(v);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    live = (v < 1) ? 1 : (v > MAX_NODES_DEF ? MAX_NODES_DEF : v);
  endtask

  function automatic int pick_node();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, live);
    if (r < 87) return 0;
    if (r < 94 && live < 2047) return $urandom_range(live + 1, 2047);
    return $urandom & 11'h7ff;
  endfunction

  task automatic load_tree(int nodes, bit chain);
    int p;
    for (int i = 2; i <= nodes; i++) begin
      p = chain ? i - 1 : $urandom_range(1, i - 1);
      if ($urandom_range(0, 1)) send_item(KIND_EDGE, i, p);
      else send_item(KIND_EDGE, p, i);
    end
  endtask

  initial begin
    int cfg_v, tree_n;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Queries against the cleared tables, before any build.
    send_item(KIND_QUERY, 1, 1);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, 2047, 1);
    send_item(KIND_UNUSED, 2047, 2047);
    write_node_count(8);
    send_item(KIND_QUERY, 3, 5);
    load_tree(7, 1'b0);
    send_item(KIND_EDGE, 0, 2);
    send_item(KIND_EDGE, 2047, 1);
    send_item(KIND_BUILD, 0, 0);
    send_item(KIND_QUERY, 4, 4);
    send_item(KIND_QUERY, 1, 7);
    send_item(KIND_QUERY, 6, 7);
    send_item(KIND_QUERY, 8, 3);
    send_item(KIND_QUERY, 0, 5);
    send_item(KIND_QUERY, 9, 2);
    send_item(KIND_QUERY, 2047, 1024);
    send_item(KIND_UNUSED, 1, 2);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) cfg_v = 2047;
      else if (ph == 1) cfg_v = 0;
      else cfg_v = $urandom_range(2, 40);
      write_node_count(cfg_v);
      tree_n = (live > 30) ? 30 : live;
      if (live == 1) tree_n = 4;
      load_tree(tree_n, ph % 3 == 2);
      if (live == MAX_NODES_DEF) begin
        send_item(KIND_EDGE, tree_n, 1024);
        send_item(KIND_EDGE, 1024, 1023);
      end
      if ($urandom_range(0, 1)) send_item(KIND_EDGE, pick_node(), pick_node());
      send_item(KIND_BUILD, 0, 0);
      for (int q = 0; q < 85; q++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(KIND_UNUSED, $urandom & 11'h7ff, $urandom & 11'h7ff);
        end else if ($urandom_range(0, 29) == 0) begin
          send_item(KIND_BUILD, pick_node(), pick_node());
        end else begin
          send_item(KIND_QUERY, pick_node(), pick_node());
        end
      end
    end

    // Forty loose edges over a small count, some outside it, then a build.
    write_node_count(12);
    repeat (40) send_item(KIND_EDGE, $urandom_range(0, 20), $urandom_range(0, 20));
    send_item(KIND_BUILD, 0, 0);
    for (int q = 0; q < 30; q++) send_item(KIND_QUERY, pick_node(), pick_node());

    settle();
    repeat (50) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
